/* src/wswc_pkg.sv */
// ----------------------------------------------------------------------------
// wswc_pkg: shared types and constants of the wheel speed window counter
// Holds the sequencer states, the control word for the speed unit and the
// fixed codes and limits of the block.
// ----------------------------------------------------------------------------
package wswc_pkg;

    localparam logic [10:0] SPEED_ID_BASE = 11'h560;
    localparam logic [15:0] BIN_MAX       = 16'hFFFF;
    localparam logic [15:0] SPEED_MAX     = 16'hFFFF;
    localparam logic [31:0] SCALE_RESET   = 32'h0001_0000;

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PULSE_RD,
        ST_PULSE_WR,
        ST_SUM,
        ST_SUM_TAIL,
        ST_MUL,
        ST_SAT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic accumulate;
        logic multiply;
        logic saturate;
    } unit_ctl_t;

endpackage

/* src/wheel_speed_window_counter.sv */
// ----------------------------------------------------------------------------
// wheel_speed_window_counter: sliding-window pulse-count speed meter
// Keeps a ring of pulse bins per wheel, counts pulses into the current bin
// and on each tick reports the scaled window sum as a speed word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Word
//  in        input      in_valid / in_stall      kind, wheel
//  out       output     out_valid / out_stall    out_wheel, speed, message_id
//  cfg       input      cfg_valid / cfg_ready    cfg_data (scale factor)
//
//  A pulse passes through ST_PULSE_RD and ST_PULSE_WR before the next
//  acceptance; a tick steps through ST_SUM, reading one bin per cycle from the
//  bin memory, then ST_SUM_TAIL, ST_MUL, ST_SAT and ST_FINISH. After reset a
//  clearing pass zeroes every bin memory entry, one entry per cycle, while
//  in_stall stays high. A tick waits in its last step while output is stalled.
//
module wheel_speed_window_counter
    import wswc_pkg::*;
#(
    parameter int WINDOW_SLOTS = 8,
    parameter int WHEELS       = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic        wheel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_wheel,
    output logic [15:0] speed,
    output logic [10:0] message_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int WHEEL_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam int ADDR_W  = WHEEL_W + SLOT_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int SUM_W   = 16 + $clog2(WINDOW_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [SLOT_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]   cnt_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [ADDR_W-1:0]   clr_addr_next;
    logic [WHEEL_W-1:0]  wheel_reg;
    logic [WHEEL_W-1:0]  wheel_next;
    logic                acc_pend_reg;
    logic                acc_pend_next;
    logic [31:0]         scale_reg;
    logic [SLOT_W-1:0]   slot_reg [WHEELS];

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_wheel_reg;
    logic [15:0]         speed_out_reg;
    logic [10:0]         msg_reg;

    logic [15:0]         bin_mem [DEPTH];
    logic [15:0]         rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [15:0]         mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic                wheel_ok;
    logic [SLOT_W-1:0]   cur_slot;
    logic [SLOT_W-1:0]   nxt_slot;
    logic                out_load;
    logic [15:0]         unit_speed;
    unit_ctl_t           ctl;

    assign wheel_ok  = (32'(wheel) < WHEELS);
    assign cur_slot  = slot_reg[wheel_reg];
    assign nxt_slot  = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_addr_next = clr_addr_reg;
        wheel_next    = wheel_reg;
        acc_pend_next = 1'b0;
        in_stall      = 1'b1;
        mem_we        = 1'b0;
        mem_waddr     = {wheel_reg, cur_slot};
        mem_wdata     = 16'd0;
        mem_re        = 1'b0;
        mem_raddr     = {wheel_reg, cur_slot};
        out_load      = 1'b0;
        ctl           = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && wheel_ok)
                begin
                    wheel_next = WHEEL_W'(wheel);
                    cnt_next   = '0;
                    if (kind == KIND_TICK)
                    begin
                        ctl.clear  = 1'b1;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_PULSE_RD;
                    end
                end
            end
            ST_PULSE_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_PULSE_WR;
            end
            ST_PULSE_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = (rd_data_reg == BIN_MAX) ? rd_data_reg : rd_data_reg + 16'd1;
                state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                mem_re         = 1'b1;
                mem_raddr      = {wheel_reg, cnt_reg};
                acc_pend_next  = 1'b1;
                ctl.accumulate = acc_pend_reg;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_SUM_TAIL;
                end
            end
            ST_SUM_TAIL:
            begin
                ctl.accumulate = acc_pend_reg;
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.multiply = 1'b1;
                state_next   = ST_SAT;
            end
            ST_SAT:
            begin
                ctl.saturate = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = {wheel_reg, nxt_slot};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_addr_reg  <= '0;
            wheel_reg     <= '0;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scale_reg     <= SCALE_RESET;
            for (int i = 0; i < WHEELS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_addr_reg  <= clr_addr_next;
            wheel_reg     <= wheel_next;
            acc_pend_reg  <= acc_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                scale_reg <= cfg_data;
            end
            if (out_load)
            begin
                slot_reg[wheel_reg] <= nxt_slot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_wheel_reg <= wheel_reg[0];
            speed_out_reg <= unit_speed;
            msg_reg       <= SPEED_ID_BASE + 11'(wheel_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= bin_mem[mem_raddr];
        end
    end

    wswc_speed_unit #(
        .SUM_W (SUM_W)
    ) u_speed_unit (
        .clk      (clk),
        .ctl      (ctl),
        .bin_data (rd_data_reg),
        .scale    (scale_reg),
        .speed    (unit_speed)
    );

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_wheel  = out_wheel_reg;
    assign speed      = speed_out_reg;
    assign message_id = msg_reg;

endmodule

/* src/wswc_speed_unit.sv */
// ----------------------------------------------------------------------------
// wswc_speed_unit: shared accumulate, scale and saturate unit
// Adds one bin per step into the window sum, multiplies it by the Q16.16 scale
// factor and clamps the integer part to a 16-bit speed; a bare fraction is 1.
// ----------------------------------------------------------------------------
module wswc_speed_unit
    import wswc_pkg::*;
#(
    parameter int SUM_W = 19
)
(
    input  logic        clk,
    input  unit_ctl_t   ctl,
    input  logic [15:0] bin_data,
    input  logic [31:0] scale,
    output logic [15:0] speed
);

    localparam int PROD_W = SUM_W + 32;

    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  acc_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [15:0]       speed_reg;
    logic [15:0]       speed_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.accumulate)
        begin
            acc_next = acc_reg + SUM_W'(bin_data);
        end
    end

    always_comb
    begin
        prod_next = prod_reg;
        if (ctl.multiply)
        begin
            prod_next = PROD_W'(acc_reg) * PROD_W'(scale);
        end
    end

    always_comb
    begin
        speed_next = speed_reg;
        if (ctl.saturate)
        begin
            if (|prod_reg[PROD_W-1:32])
            begin
                speed_next = SPEED_MAX;
            end
            else if ((prod_reg[31:16] == 16'd0) && (prod_reg[15:0] != 16'd0))
            begin
                speed_next = 16'd1;
            end
            else
            begin
                speed_next = prod_reg[31:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        speed_reg <= speed_next;
    end

    assign speed = speed_reg;

endmodule
